### rtl/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

  // Input transaction: one value plus its formatting flags
  typedef struct packed {
    logic signed [31:0] value;
    logic               zero_flag;
    logic               left_flag;
    logic               precision_given;
    logic [5:0]         precision;
    logic [5:0]         width;
  } sdf_in_t;

  // Result transaction: one character of the text
  typedef struct packed {
    logic [7:0] character;
    logic       char_valid;
    logic       last;
    logic [6:0] total_length;
  } sdf_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture input transaction, start conversion
    logic step;   // two binary-to-BCD iterations
    logic size;   // work out digit count, padding and length
    logic emit;   // load next character into the output register
  } sdf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a character this cycle
    logic last_char;  // character offered now is the final one
  } sdf_status_t;

  // Conversion: 32 magnitude bits, two per cycle
  localparam int unsigned ConvCycles = 16;
  localparam int unsigned ConvCntW   = $clog2(ConvCycles);

endpackage

`default_nettype wire

### rtl/sdf_ctrl.sv
`default_nettype none

module sdf_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sdf_pkg::sdf_status_t status,
  output sdf_pkg::sdf_cmd_t    cmd
);
  import sdf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [ConvCntW-1:0] cnt_r, cnt_nxt;

  // Sequence one transaction: convert, size, then stream characters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == ConvCntW'(ConvCycles - 1)) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_char) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sdf_dp.sv
`default_nettype none

module sdf_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sdf_pkg::sdf_in_t     in_data,
  input  sdf_pkg::sdf_cmd_t    cmd,
  output sdf_pkg::sdf_status_t status,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sdf_pkg::sdf_out_t    out_data
);
  import sdf_pkg::*;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;

  // One shift-add-3 iteration: adjust each BCD digit, shift in one bit
  function automatic logic [39:0] dabble(input logic [39:0] bcd, input logic bit_in);
    logic [39:0] adj;
    adj = bcd;
    for (int d = 0; d < 10; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
    end
    return {adj[38:0], bit_in};
  endfunction

  logic [31:0] bin_r;
  logic [39:0] bcd_r;
  logic        neg_r, fill_r, prec_given_r, is_zero_r, empty_r;
  logic [5:0]  prec_r, wid_r;
  logic [6:0]  pre_r, total_r, k_r;
  logic [3:0]  dig_r;
  logic        out_valid_r;
  sdf_out_t    out_data_r;

  logic [31:0] mag;
  logic [39:0] bcd_one;
  logic [3:0]  hi_dig, ndig;
  logic [6:0]  sign_len, body, zeros, prec_eff, total_nxt;
  logic        empty_nxt;
  sdf_out_t    res;

  assign mag     = in_data.value[31] ? (~in_data.value + 32'd1) : in_data.value;
  assign bcd_one = dabble(bcd_r, bin_r[31]);

  // Digit count from the highest nonzero BCD digit; zero has one digit
  always_comb begin
    hi_dig = 4'd0;
    for (int d = 0; d < 10; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        hi_dig = 4'(d);
      end
    end
  end
  assign ndig = hi_dig + 4'd1;

  // Padding: zero-fill to width, or pad digits up to precision
  always_comb begin
    sign_len  = {6'd0, neg_r};
    body      = sign_len + {3'd0, ndig};
    prec_eff  = prec_given_r ? {1'b0, prec_r} : 7'd0;
    zeros     = 7'd0;
    if (fill_r) begin
      if (body < {1'b0, wid_r}) begin
        zeros = {1'b0, wid_r} - body;
      end
    end else if ({3'd0, ndig} < prec_eff) begin
      zeros = prec_eff - {3'd0, ndig};
    end
    empty_nxt = is_zero_r && prec_given_r && (prec_r == 6'd0);
    total_nxt = empty_nxt ? 7'd0 : (body + zeros);
  end

  // Character for the current position, and output register space
  always_comb begin
    res = '0;
    status.out_free  = !out_valid_r || out_ready;
    status.last_char = empty_r || (k_r + 7'd1 == total_r);
    if (!empty_r) begin
      res.char_valid = 1'b1;
      if (neg_r && (k_r == 7'd0)) begin
        res.character = CharMinus;
      end else if (k_r < pre_r) begin
        res.character = CharZero;
      end else begin
        res.character = CharZero + {4'd0, bcd_r[dig_r*4 +: 4]};
      end
    end
    res.last = status.last_char;
    res.total_length = status.last_char ? total_r : 7'd0;
  end

  // Capture, convert, size and advance through the text
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r        <= mag;
      bcd_r        <= '0;
      neg_r        <= in_data.value[31];
      fill_r       <= in_data.zero_flag && !in_data.left_flag && !in_data.precision_given;
      prec_given_r <= in_data.precision_given;
      prec_r       <= in_data.precision;
      wid_r        <= in_data.width;
      is_zero_r    <= (in_data.value == 32'sd0);
    end
    if (cmd.step) begin
      bcd_r <= dabble(bcd_one, bin_r[30]);
      bin_r <= {bin_r[29:0], 2'b00};
    end
    if (cmd.size) begin
      pre_r   <= sign_len + zeros;
      total_r <= total_nxt;
      empty_r <= empty_nxt;
      k_r     <= 7'd0;
      dig_r   <= hi_dig;
    end
    if (cmd.emit) begin
      k_r <= k_r + 7'd1;
      if (!(neg_r && (k_r == 7'd0)) && !(k_r < pre_r)) begin
        dig_r <= dig_r - 4'd1;
      end
    end
  end

  // Output register: hold until taken, refill on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/signed_decimal_formatter_unit.sv
// Signed decimal formatter.
// Input channel (in_valid/in_ready/in_data) takes one signed 32-bit value with
// printf-style flags; the result channel (out_valid/out_ready/out_data) returns
// the text one character per transaction: minus sign, leading zeros, digits.
// The final transaction of each input has last set and carries total_length.
// A zero value with an explicit precision of 0 yields a single transaction
// with char_valid clear and total_length 0.
// Timing: after acceptance, binary-to-BCD conversion (two bits
// per cycle in the shift-add-3 unit), a sizing state, then one character
// per cycle while the receiver keeps out_ready high.
// One input is processed at a time; in_ready is high only between items, and
// may rise while the final character still waits in the output register.
// A stalled receiver freezes character generation; the output register holds
// its transaction until out_ready is seen.
// Reset (rst_n low, synchronous) drops any item in progress and empties the
// output register.
`default_nettype none

module signed_decimal_formatter_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  sdf_pkg::sdf_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output sdf_pkg::sdf_out_t  out_data
);
  import sdf_pkg::*;

  sdf_cmd_t    cmd;
  sdf_status_t status;

  // Sequencer
  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion and character datapath
  sdf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 138;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  // Predicts the character stream of each value and checks the result transactions
  class decimal_text_checker;
    sdf_out_t expected_chars[$];
    int errors;
    int chars_checked;
    int empty_texts;
    int longest_text;

    function new();
      errors = 0;
      chars_checked = 0;
      empty_texts = 0;
      longest_text = 0;
    endfunction

    // Format one accepted input into its expected characters
    function void note_input(sdf_in_t item);
      logic [31:0] mag;
      logic [31:0] rest;
      logic [7:0] rev_digits[$];
      logic [7:0] text[$];
      logic [5:0] min_digits;
      logic neg;
      int zeros;
      int used;
      sdf_out_t ch;
      neg = item.value[31];
      mag = item.value;
      if (neg) mag = ~mag + 32'd1;
      min_digits = item.precision_given ? item.precision : 6'd0;

      // Zero with an explicit precision of 0 prints nothing
      if (mag == 32'd0 && item.precision_given && item.precision == 6'd0) begin
        ch = '0;
        ch.last = 1'b1;
        expected_chars.push_back(ch);
        empty_texts++;
        return;
      end

      // Collect digits least significant first
      rest = mag;
      do begin
        rev_digits.push_back(CHAR_ZERO + 8'(rest % 32'd10));
        rest = rest / 32'd10;
      end while (rest != 32'd0);

      // Zero-fill to width counts the sign; otherwise pad digits to precision
      used = rev_digits.size() + (neg ? 1 : 0);
      zeros = 0;
      if (item.zero_flag && !item.left_flag && !item.precision_given) begin
        if (used < int'(item.width)) zeros = int'(item.width) - used;
      end else begin
        if (rev_digits.size() < int'(min_digits))
          zeros = int'(min_digits) - rev_digits.size();
      end

      if (neg) text.push_back(CHAR_MINUS);
      repeat (zeros) text.push_back(CHAR_ZERO);
      while (rev_digits.size() != 0) text.push_back(rev_digits.pop_back());

      foreach (text[i]) begin
        ch.character = text[i];
        ch.char_valid = 1'b1;
        ch.last = (i == text.size() - 1);
        ch.total_length = ch.last ? 7'(text.size()) : 7'd0;
        expected_chars.push_back(ch);
      end
      if (text.size() > longest_text) longest_text = text.size();
    endfunction

    // Compare one result transaction with the oldest expected character
    function void check_char(sdf_out_t got);
      sdf_out_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none,", $time);
        $display("%0t:   actual char=%02h valid=%0d last=%0d len=%0d",
                 $time, got.character, got.char_valid, got.last, got.total_length);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.character !== want.character || got.char_valid !== want.char_valid ||
          got.last !== want.last || got.total_length !== want.total_length) begin
        $display("%0t: character mismatch: expected char=%02h valid=%0d last=%0d len=%0d",
                 $time, want.character, want.char_valid, want.last, want.total_length);
        $display("%0t:                      actual   char=%02h valid=%0d last=%0d len=%0d",
                 $time, got.character, got.char_valid, got.last, got.total_length);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sdf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdf_out_t out_data;

  // No idling on either side while this is set
  logic steady = 1'b0;
  int unsigned cycle_count = 0;
  int values_sent = 0;
  decimal_text_checker text_sb = new();

  signed_decimal_formatter_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Stall the receiver at random outside the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) text_sb.check_char(out_data);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d characters still expected",
               $time, cycle_count, text_sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one value, idling at random first, and hold it until accepted
  task automatic send_item(input sdf_in_t item);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    text_sb.note_input(item);
    values_sent++;
  endtask

  task automatic send_fields(input logic signed [31:0] value, input logic zf, input logic lf,
                             input logic pg, input logic [5:0] prec, input logic [5:0] wid);
    sdf_in_t item;
    item.value = value;
    item.zero_flag = zf;
    item.left_flag = lf;
    item.precision_given = pg;
    item.precision = prec;
    item.width = wid;
    send_item(item);
  endtask

  // Mix of full-range, small, near powers of ten and extreme values
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(200);
      2: begin
        v = 1;
        repeat ($urandom_range(9)) v = v * 10;
        v = v + $urandom_range(2) - 1;
      end
      3: v = $urandom_range(1) ? INT_MIN + $urandom_range(3) : INT_MAX - $urandom_range(3);
      default: v = $urandom_range(99999);
    endcase
    if ($urandom_range(1) && v != INT_MIN) v = -v;
    return v;
  endfunction

  // Mostly short fields, now and then up to the saturated size
  function automatic logic [5:0] pick_size();
    return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
  endfunction

  initial begin
    int directed_count;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both padding modes, empty zero, ignored precision
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 1, 0, 0);
    send_fields(0, 1, 0, 1, 0, 63);
    send_fields(0, 0, 0, 1, 5, 0);
    send_fields(0, 1, 0, 0, 0, 63);
    send_fields(INT_MIN, 0, 0, 0, 0, 0);
    send_fields(INT_MIN, 0, 0, 1, 63, 0);
    send_fields(INT_MIN, 1, 0, 0, 0, 63);
    send_fields(INT_MAX, 1, 0, 0, 0, 63);
    send_fields(INT_MAX, 0, 1, 1, 63, 63);
    send_fields(-1, 0, 0, 0, 0, 0);
    send_fields(-1, 1, 0, 0, 0, 1);
    send_fields(-5, 1, 0, 0, 0, 2);
    send_fields(-5, 1, 0, 0, 0, 3);
    send_fields(1234567890, 1, 1, 0, 0, 20);
    send_fields(-42, 1, 0, 1, 0, 10);
    send_fields(77, 0, 0, 0, 63, 63);
    send_fields(7, 0, 0, 1, 1, 0);
    send_fields(1000000000, 0, 0, 1, 12, 0);
    send_fields(-999999999, 1, 1, 1, 9, 40);
    send_fields(9, 1, 0, 0, 0, 63);
    send_fields(10, 0, 1, 0, 0, 0);
    directed_count = values_sent;

    // Random values, with one stretch of back-to-back traffic in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sdf_in_t item;
      steady <= (n >= 60 && n < 100);
      item.value = pick_value();
      item.zero_flag = 1'($urandom_range(1));
      item.left_flag = ($urandom_range(3) == 0);
      item.precision_given = 1'($urandom_range(1));
      item.precision = pick_size();
      item.width = pick_size();
      send_item(item);
    end
    in_valid <= 1'b0;

    // Drain, then let any stray transaction show up
    while (text_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Formatted %0d values (%0d directed) into %0d checked characters.",
             values_sent, directed_count, text_sb.chars_checked);
    $display("Empty-zero results: %0d, longest text: %0d characters.",
             text_sb.empty_texts, text_sb.longest_text);
    if (text_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/sdf_pkg.sv
rtl/sdf_ctrl.sv
rtl/sdf_dp.sv
rtl/signed_decimal_formatter_unit.sv
sim/testbench.sv
